>>> design/ctcg_pkg.sv
// Shared types and constants of the CTC greedy decoder.
`default_nettype none

package ctcg_pkg;

    // Fixed field widths of the streams.
    localparam int LOGIT_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int CLASS_W  = 8;
    localparam int SUM_W    = LOGIT_W + COUNT_W;
    localparam int CC_W     = 9;

    // Marker for "no previously emitted class".
    localparam logic [CC_W-1:0] NO_CLASS = '1;

    // Configuration register map.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_CLASS_COUNT = '0;
    localparam logic [CC_W-1:0]   CLASS_COUNT_RST = 9'd2;

    // Result kinds carried on tuser.
    localparam logic KIND_SYMBOL  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    // One closed row or sequence end, handed from the front to the back.
    typedef struct packed {
        logic                      has_sym;
        logic [CLASS_W-1:0]        cls;
        logic signed [LOGIT_W-1:0] val;
        logic [COUNT_W-1:0]        cnt;
        logic                      has_eos;
        logic signed [SUM_W-1:0]   sum;
    } t_row_evt;

    // Handshake between queue and its users.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

>>> design/ctcg_front.sv
// Front part: per-row argmax, repeat collapsing and running count and sum.
`default_nettype none

module ctcg_front #(
    parameter int MAX_CLASSES = 256
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire [ctcg_pkg::CC_W-1:0]            i_class_count,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire signed [ctcg_pkg::LOGIT_W-1:0]  i_logit,
    input  wire                                 i_eos,
    input  ctcg_pkg::t_queue_status             i_q_status,
    output logic                                o_push,
    output ctcg_pkg::t_row_evt                  o_evt
);

    localparam int PW = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;

    logic [PW-1:0]                         r_pos;
    logic signed [ctcg_pkg::LOGIT_W-1:0]   r_best_val;
    logic [ctcg_pkg::CLASS_W-1:0]          r_best_cls;
    logic [ctcg_pkg::CC_W-1:0]             r_prev;
    logic [ctcg_pkg::COUNT_W-1:0]          r_total;
    logic signed [ctcg_pkg::SUM_W-1:0]     r_sum;

    logic [ctcg_pkg::CC_W-1:0]             w_n_eff;
    logic                                  w_accept;
    logic                                  w_first;
    logic                                  w_take;
    logic                                  w_close;
    logic                                  w_sym;
    logic                                  w_inc;
    logic signed [ctcg_pkg::LOGIT_W-1:0]   n_best_val;
    logic [ctcg_pkg::CLASS_W-1:0]          n_best_cls;
    logic [ctcg_pkg::COUNT_W-1:0]          n_total;
    logic signed [ctcg_pkg::SUM_W-1:0]     n_sum;

    always_comb begin
        if (i_class_count < ctcg_pkg::CC_W'(2)) begin
            w_n_eff = ctcg_pkg::CC_W'(2);
        end else if (i_class_count > ctcg_pkg::CC_W'(MAX_CLASSES)) begin
            w_n_eff = ctcg_pkg::CC_W'(MAX_CLASSES);
        end else begin
            w_n_eff = i_class_count;
        end
    end

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;

    // The first class of a row always loads; later ones must be strictly greater.
    assign w_first    = (r_pos == '0);
    assign w_take     = w_first || (i_logit > r_best_val);
    assign n_best_val = w_take ? i_logit : r_best_val;
    assign n_best_cls = w_first ? '0 :
                        (w_take ? ctcg_pkg::CLASS_W'(r_pos) : r_best_cls);

    assign w_close = i_eos ||
                     ((ctcg_pkg::CC_W'(r_pos) + ctcg_pkg::CC_W'(1)) >= w_n_eff);
    assign w_sym   = w_close && (n_best_cls != '0) &&
                     ({1'b0, n_best_cls} != r_prev);
    assign w_inc   = w_sym && (r_total != '1);
    assign n_total = r_total + ctcg_pkg::COUNT_W'(w_inc);
    assign n_sum   = w_inc ? (r_sum + ctcg_pkg::SUM_W'(n_best_val)) : r_sum;

    assign o_push        = w_accept && (w_sym || i_eos);
    assign o_evt.has_sym = w_sym;
    assign o_evt.cls     = n_best_cls;
    assign o_evt.val     = n_best_val;
    assign o_evt.cnt     = n_total;
    assign o_evt.has_eos = i_eos;
    assign o_evt.sum     = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_best_val <= '0;
            r_best_cls <= '0;
            r_prev     <= ctcg_pkg::NO_CLASS;
            r_total    <= '0;
            r_sum      <= '0;
        end else if (w_accept) begin
            if (i_eos) begin
                r_pos      <= '0;
                r_best_val <= '0;
                r_best_cls <= '0;
                r_prev     <= ctcg_pkg::NO_CLASS;
                r_total    <= '0;
                r_sum      <= '0;
            end else begin
                r_best_val <= n_best_val;
                r_best_cls <= n_best_cls;
                r_total    <= n_total;
                r_sum      <= n_sum;
                if (w_close) begin
                    r_pos <= '0;
                    if (n_best_cls == '0) begin
                        r_prev <= ctcg_pkg::NO_CLASS;
                    end else if (w_sym) begin
                        r_prev <= {1'b0, n_best_cls};
                    end
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/ctcg_queue.sv
// Short event queue between the front and the back part.
`default_nettype none

module ctcg_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  ctcg_pkg::t_row_evt      i_evt,
    input  wire                     i_pop,
    output ctcg_pkg::t_row_evt      o_head,
    output ctcg_pkg::t_queue_status o_status
);

    localparam int AW = $clog2(ctcg_pkg::QUEUE_DEPTH);

    ctcg_pkg::t_row_evt r_mem [ctcg_pkg::QUEUE_DEPTH];
    logic [AW:0]        r_wr_ptr;
    logic [AW:0]        r_rd_ptr;

    assign o_status.empty = (r_wr_ptr == r_rd_ptr);
    assign o_status.full  = (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]) &&
                            (r_wr_ptr[AW] != r_rd_ptr[AW]);
    assign o_head = r_mem[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_status.full) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_status.full) begin
                r_wr_ptr <= r_wr_ptr + (AW+1)'(1);
            end
            if (i_pop && !o_status.empty) begin
                r_rd_ptr <= r_rd_ptr + (AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/ctcg_div.sv
// Bit-serial signed divider for the sequence mean, one quotient bit a cycle.
`default_nettype none

module ctcg_div (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_start,
    input  wire signed [ctcg_pkg::SUM_W-1:0]     i_dividend,
    input  wire [ctcg_pkg::COUNT_W-1:0]          i_divisor,
    output logic                                 o_done,
    output logic signed [ctcg_pkg::LOGIT_W-1:0]  o_quot
);

    localparam int SW = ctcg_pkg::SUM_W;
    localparam int DW = ctcg_pkg::COUNT_W;
    localparam int CW = $clog2(SW + 1);

    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic          r_neg;

    logic [DW:0]   w_rem_sh;
    logic          w_ge;
    logic [DW:0]   w_diff;
    logic [ctcg_pkg::LOGIT_W-1:0] w_mag;

    assign w_rem_sh = {r_rem, r_q[SW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});
    assign w_diff   = w_rem_sh - {1'b0, r_div};

    assign o_done = (r_cnt == '0);
    // A zero divisor only happens with an empty sequence; the mean is then zero.
    assign w_mag  = (r_div == '0) ? '0 : r_q[ctcg_pkg::LOGIT_W-1:0];
    assign o_quot = r_neg ? -$signed(w_mag) : $signed(w_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(SW);
        end else if (!o_done) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[SW-1] ? -i_dividend : i_dividend;
            r_neg <= i_dividend[SW-1];
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (!o_done) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
            r_q   <= {r_q[SW-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

>>> design/ctcg_back.sv
// Back part: drains the event queue into the result register, runs the mean division.
`default_nettype none

module ctcg_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  ctcg_pkg::t_queue_status          i_q_status,
    input  ctcg_pkg::t_row_evt               i_head,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic                             o_kind,
    output logic [ctcg_pkg::CLASS_W-1:0]     o_cls,
    output logic [ctcg_pkg::LOGIT_W-1:0]     o_conf,
    output logic [ctcg_pkg::COUNT_W-1:0]     o_cnt,
    output logic                             o_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SYM  = 3'b010,
        S_SUM  = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    ctcg_pkg::t_row_evt r_evt;

    logic                                w_out_free;
    logic                                w_load_sym;
    logic                                w_load_sum;
    logic                                w_div_done;
    logic signed [ctcg_pkg::LOGIT_W-1:0] w_quot;

    assign w_out_free = !o_valid || i_ready;

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_load_sym = 1'b0;
        w_load_sum = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = i_head.has_sym ? S_SYM : S_SUM;
                end
            end
            S_SYM: begin
                if (w_out_free) begin
                    w_load_sym = 1'b1;
                    n_state    = r_evt.has_eos ? S_SUM : S_IDLE;
                end
            end
            S_SUM: begin
                if (w_out_free && w_div_done) begin
                    w_load_sum = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    ctcg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (o_pop && i_head.has_eos),
        .i_dividend (i_head.sum),
        .i_divisor  (i_head.cnt),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_sym || w_load_sum) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_evt <= i_head;
        end
        if (w_load_sym) begin
            o_kind <= ctcg_pkg::KIND_SYMBOL;
            o_cls  <= r_evt.cls;
            o_conf <= r_evt.val;
            o_cnt  <= r_evt.cnt;
            o_last <= 1'b0;
        end else if (w_load_sum) begin
            o_kind <= ctcg_pkg::KIND_SUMMARY;
            o_cls  <= '0;
            o_conf <= w_quot;
            o_cnt  <= r_evt.cnt;
            o_last <= 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> design/ctc_greedy_decoder.sv
// Top level of the streaming CTC greedy (best-path) decoder.
//
// Input stream: one signed Q8.8 logit per transfer on i_s_tdata, row by row,
// class_count logits per time step; i_s_tlast marks the final logit of the
// sequence and also closes the row it falls in. One logit is taken per cycle.
// Output stream: a symbol result (tuser 0) for each row whose argmax is not
// blank and not a repeat of the previous row's class, and one summary
// (tuser 1, tlast 1) per sequence holding the truncated mean logit of the
// counted symbols and their count.
// A symbol result goes from the queue to r_evt and then to the output register.
// The summary follows the final logit once the mean is ready: the mean comes
// from a bit-serial divider that resolves one of 32 quotient bits a cycle.
// A four-entry queue separates the row tracking from the result side, so
// logits keep streaming while the receiver stalls or the divider runs; the
// input stalls only once that queue is full.
// class_count lives at APB byte address 0 and is written by the user only while idle;
// the block does not enforce this. Reset is synchronous: class_count returns to 2,
// the queue and the output register empty and all sequence state clears.
`default_nettype none

module ctc_greedy_decoder #(
    parameter int MAX_CLASSES = 256
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Logit input stream
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire [15:0]                         i_s_tdata,   // [15:0] logit
    input  wire                                i_s_tlast,   // end_of_sequence
    // Result output stream
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // [7:0] class_index, [23:8] confidence, [39:24] emitted_count
    output logic [39:0]                        o_m_tdata,
    output logic                               o_m_tuser,   // [0] kind
    output logic                               o_m_tlast,   // last
    // Configuration port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [ctcg_pkg::APB_AW-1:0]         paddr,
    input  wire [ctcg_pkg::APB_DW-1:0]         pwdata,
    output logic [ctcg_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    logic [ctcg_pkg::CC_W-1:0]    r_class_count;

    ctcg_pkg::t_row_evt           w_push_evt;
    ctcg_pkg::t_row_evt           w_head;
    ctcg_pkg::t_queue_status      w_q_status;
    logic                         w_push;
    logic                         w_pop;
    logic                         w_reg_sel;
    logic [ctcg_pkg::CLASS_W-1:0] w_cls;
    logic [ctcg_pkg::LOGIT_W-1:0] w_conf;
    logic [ctcg_pkg::COUNT_W-1:0] w_cnt;

    // Register file: a single register, class_count.
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[ctcg_pkg::APB_AW-1:2] == ctcg_pkg::REG_CLASS_COUNT);
    assign prdata    = w_reg_sel ? ctcg_pkg::APB_DW'(r_class_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count <= ctcg_pkg::CLASS_COUNT_RST;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_class_count <= pwdata[ctcg_pkg::CC_W-1:0];
        end
    end

    // Front: classifies each logit and closes rows.
    ctcg_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_class_count (r_class_count),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_logit       ($signed(i_s_tdata)),
        .i_eos         (i_s_tlast),
        .i_q_status    (w_q_status),
        .o_push        (w_push),
        .o_evt         (w_push_evt)
    );

    ctcg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_evt    (w_push_evt),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // Back: turns row events into result transfers.
    ctcg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_kind     (o_m_tuser),
        .o_cls      (w_cls),
        .o_conf     (w_conf),
        .o_cnt      (w_cnt),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {w_cnt, w_conf, w_cls};

endmodule

`default_nettype wire

>>> design/ctcg_chk.sv
// Port-level checker for the CTC greedy decoder, bound to the top level.
`default_nettype none

module ctcg_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [39:0] o_m_tdata,
    input wire        o_m_tuser,
    input wire        o_m_tlast
);

    // Only the summary closes a sequence.
    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == o_m_tuser))
        else $error("tlast does not match the summary kind");

    // A summary carries class index zero.
    a_summary_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[7:0] == 8'd0))
        else $error("summary with nonzero class index");

    // Blank is never emitted, and an emitted symbol always has a nonzero count.
    a_symbol_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |->
            ((o_m_tdata[7:0] != 8'd0) && (o_m_tdata[39:24] != 16'd0)))
        else $error("symbol result with blank class or zero count");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result changed while stalled");

endmodule

bind ctc_greedy_decoder ctcg_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
